// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the sort engine RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/fse_pkg.sv =====
// Package for the float sort engine: widths, defaults, float compare.
// No dependencies.
package fse_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned MaxElementsDef = 64;

  // numeric a < b, false when either side is NaN; -0 == +0
  function automatic logic f_less(input logic [DataW-1:0] a, input logic [DataW-1:0] b);
    logic an, bn;
    logic [DataW:0] ka, kb;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    ka = a[31] ? (33'h100000000 - {2'b00, a[30:0]}) : (33'h100000000 + {2'b00, a[30:0]});
    kb = b[31] ? (33'h100000000 - {2'b00, b[30:0]}) : (33'h100000000 + {2'b00, b[30:0]});
    return !an && !bn && (ka < kb);
  endfunction
endpackage

// ===== hw/rtl/fse_cell.sv =====
// One sorting cell: holds one stored value and compare-swaps it with its right neighbor.
// Depends on fse_pkg.
module fse_cell import fse_pkg::*; #(
  parameter int unsigned Idx = 0,
  parameter int unsigned TW = 8
) (
  input  logic             clk,
  input  logic             load,
  input  logic             shift,
  input  logic             sort_en,
  input  logic             ascending,
  input  logic [TW-1:0]    step,
  input  logic [TW-1:0]    last_step,
  input  logic [DataW-1:0] in_val,
  input  logic             left_swap,
  input  logic [DataW-1:0] left_val,
  input  logic [DataW-1:0] right_val,
  output logic             swap,
  output logic [DataW-1:0] val
);
  localparam logic [TW-1:0] Pos = TW'(Idx);

  logic [DataW-1:0] val_r, val_nxt;
  logic             active;

  // pass p compares this pair at step 2p + Idx; each pass stops short of the sorted tail
  assign active = sort_en && (step >= Pos) && (step[0] == Pos[0])
                  && ((step + Pos) <= last_step);
  // strict compare only, so equal values and NaNs never move
  assign swap = active && (ascending ? f_less(right_val, val_r) : f_less(val_r, right_val));

  always_comb begin
    val_nxt = val_r;
    if (load) begin
      val_nxt = in_val;
    end else if (shift || swap) begin
      val_nxt = right_val;
    end else if (left_swap) begin
      val_nxt = left_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
endmodule

// ===== hw/rtl/float_sort_engine_top.sv =====
// Float sort engine: chain of MaxElements cells running a pipelined bubble sort.
// Results follow once the sort of a set is done (no sort for a single element), then
// one result per cycle while out_tready is high.
// Throughput: one request per cycle while loading; no request is taken during sort or drain.
// Set phases: load, sort, drain, turnaround. Depends on fse_pkg, fse_cell, assert_macros.svh.
// Reset: rst_n synchronous, clears counts, flags and state, sets sort_ascending to 1.
`include "assert_macros.svh"
module float_sort_engine_top import fse_pkg::*; #(
  parameter int unsigned MaxElements = MaxElementsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // sort_ascending
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,       // [31:0] sample_value
  input  logic        in_tlast,       // final_element
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,      // [31:0] sorted_value
  output logic        out_tlast,      // final_result
  output logic        out_tuser       // overflowed
);
  localparam int unsigned CW = $clog2(MaxElements + 1);
  localparam int unsigned TW = $clog2(3 * MaxElements);

  typedef enum logic [1:0] {S_LOAD, S_SORT, S_DRAIN} state_t;
  state_t state_r;
  logic asc_r, run_asc_r, ovf_r;
  logic [CW-1:0] cnt_r, left_r;
  logic [TW-1:0] step_r, last_step_r;
  logic out_v_r, out_l_r, out_u_r;
  logic [DataW-1:0] out_d_r;

  logic [DataW-1:0] cv [MaxElements];
  logic [MaxElements-1:0] swp;
  logic [CW-1:0] n_fill;
  logic shift, sort_en, acc, store;

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_LOAD);
  assign acc = in_tvalid && in_tready;
  assign store = acc && (cnt_r < CW'(MaxElements));
  assign n_fill = store ? cnt_r + CW'(1) : cnt_r;
  assign sort_en = (state_r == S_SORT);
  assign out_tvalid = out_v_r;
  assign out_tdata = out_d_r;
  assign out_tlast = out_l_r;
  assign out_tuser = out_u_r;
  // drain: cell i takes the value of cell i+1
  assign shift = (state_r == S_DRAIN) && (!out_v_r || out_tready) && (left_r != '0);

  for (genvar i = 0; i < MaxElements; i++) begin : g_c
    logic             lsw;
    logic [DataW-1:0] lv;
    logic [DataW-1:0] rv;
    if (i == 0) begin : g_l
      assign lsw = 1'b0;
      assign lv = '0;
    end else begin : g_lm
      assign lsw = swp[i-1];
      assign lv = cv[i-1];
    end
    if (i == MaxElements - 1) begin : g_e
      assign rv = '0;
    end else begin : g_m
      assign rv = cv[i+1];
    end
    fse_cell #(.Idx(i), .TW(TW)) u_cell (
      .clk, .load(store && (cnt_r == CW'(i))), .shift, .sort_en,
      .ascending(run_asc_r), .step(step_r), .last_step(last_step_r),
      .in_val(in_tdata), .left_swap(lsw), .left_val(lv), .right_val(rv),
      .swap(swp[i]), .val(cv[i]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; asc_r <= 1'b1; run_asc_r <= 1'b1; ovf_r <= 1'b0;
      cnt_r <= '0; left_r <= '0; step_r <= '0; last_step_r <= '0; out_v_r <= 1'b0;
    end else begin
      if (cfg_valid) asc_r <= cfg_data;
      if (shift) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (acc) begin
            cnt_r <= n_fill;
            if (!store) ovf_r <= 1'b1;
            if (in_tlast) begin
              run_asc_r <= asc_r;
              left_r <= n_fill;
              step_r <= '0;
              last_step_r <= TW'(n_fill) + TW'(n_fill) - TW'(4);
              state_r <= (n_fill > CW'(1)) ? S_SORT : S_DRAIN;
            end
          end
        end
        S_SORT: begin
          if (step_r == last_step_r) state_r <= S_DRAIN;
          else step_r <= step_r + TW'(1);
        end
        S_DRAIN: begin
          if (left_r == '0) begin
            state_r <= S_LOAD; cnt_r <= '0; ovf_r <= 1'b0;
          end else if (shift) begin
            left_r <= left_r - CW'(1);
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
    if (shift) begin
      out_d_r <= cv[0];
      out_l_r <= (left_r == CW'(1));
      out_u_r <= ovf_r;
    end
  end

  `ASSERT_NEVER(a_cnt_max, clk, rst_n, cnt_r > CW'(MaxElements))
  `ASSERT_NEVER(a_in_busy, clk, rst_n, acc && state_r != S_LOAD)
  `ASSERT_NEVER(a_tail_swap, clk, rst_n, swp[MaxElements-1])
  `ASSERT_IMPL(a_out_hold, clk, rst_n, out_v_r && !out_tready |=> out_v_r && $stable(out_d_r))
endmodule
